>>> rtl/core/ocp_pkg.sv
// Package for the identifier code parser: parser state, result record,
// character codes and the reset value of the state. No dependencies.
package ocp_pkg;

   localparam int GROUP_COUNT = 6;

   // Characters that the parser recognizes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_L     = 8'h4c;
   localparam logic [7:0] CH_P     = 8'h50;

   // Values of the special letters
   localparam logic [7:0] VAL_C = 8'd96;
   localparam logic [7:0] VAL_F = 8'd97;
   localparam logic [7:0] VAL_L = 8'd98;
   localparam logic [7:0] VAL_P = 8'd99;

   localparam logic [7:0] BYTE_NONE = 8'hff;

   // Group indexes (A..F)
   localparam logic [2:0] GRP_A = 3'd0;
   localparam logic [2:0] GRP_B = 3'd1;
   localparam logic [2:0] GRP_C = 3'd2;
   localparam logic [2:0] GRP_D = 3'd3;
   localparam logic [2:0] GRP_E = 3'd4;
   localparam logic [2:0] GRP_F = 3'd5;

   localparam logic [1:0] CHARS_MAX = 2'd3;

   typedef struct packed {
      logic [GROUP_COUNT-1:0][7:0] group_bytes;
      logic [7:0]                  acc_low;
      logic                        acc_over;
      logic [2:0]                  group_pos;
      logic [1:0]                  chars_in_group;
      logic                        letter_seen;
      logic                        err_flag;
   } state_type;

   typedef struct packed {
      logic [7:0] medium_res;
      logic [7:0] channel_byte;
      logic [7:0] indicator;
      logic [7:0] mode_byte;
      logic [7:0] quantity;
      logic [7:0] storage;
      logic       error;
      logic       valid_id;
      logic       vendor_specific;
   } rsp_type;

   function automatic state_type reset_state();
      state_type s;
      s.group_bytes    = {GROUP_COUNT{BYTE_NONE}};
      s.acc_low        = '0;
      s.acc_over       = 1'b0;
      s.group_pos      = GRP_A;
      s.chars_in_group = '0;
      s.letter_seen    = 1'b0;
      s.err_flag       = 1'b0;
      return s;
   endfunction

endpackage

>>> rtl/core/ocp_if.sv
// Valid/ready channel interfaces for the identifier code parser.
// Request carries one character; response carries the parsed code.
interface ocp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last_char;

   modport source (output valid, ch, last_char, input ready);
   modport sink (input valid, ch, last_char, output ready);
endinterface

interface ocp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] medium_res;
   logic [7:0] channel_byte;
   logic [7:0] indicator;
   logic [7:0] mode_byte;
   logic [7:0] quantity;
   logic [7:0] storage;
   logic       error;
   logic       valid_id;
   logic       vendor_specific;

   modport source (output valid, medium_res, channel_byte, indicator, mode_byte,
                   quantity, storage, error, valid_id, vendor_specific,
                   input ready);
   modport sink (input valid, medium_res, channel_byte, indicator, mode_byte,
                 quantity, storage, error, valid_id, vendor_specific,
                 output ready);
endinterface

>>> rtl/core/ocp_char_step.sv
// Combinational update of the parser state for one character, and the
// result record built on the final character. Depends on ocp_pkg.
module ocp_char_step (
   input  ocp_pkg::state_type cur_state,
   input  logic [7:0]         ch,
   input  logic               last_char,
   output ocp_pkg::state_type next_state,
   output ocp_pkg::rsp_type   result
);

   ocp_pkg::state_type s;
   logic [11:0] prod;
   logic [7:0]  digit;
   logic        is_digit;
   logic        is_letter;
   logic [7:0]  letter_val;
   logic [2:0]  close_grp;
   logic        close_ok;
   logic [ocp_pkg::GROUP_COUNT-1:0][7:0] b;

   // Character class and the group a separator closes
   always_comb begin
      is_digit  = (ch >= ocp_pkg::CH_ZERO) && (ch <= ocp_pkg::CH_NINE);
      digit     = ch - ocp_pkg::CH_ZERO;
      is_letter = 1'b1;
      case (ch)
         ocp_pkg::CH_C: letter_val = ocp_pkg::VAL_C;
         ocp_pkg::CH_F: letter_val = ocp_pkg::VAL_F;
         ocp_pkg::CH_L: letter_val = ocp_pkg::VAL_L;
         ocp_pkg::CH_P: letter_val = ocp_pkg::VAL_P;
         default: begin
            letter_val = '0;
            is_letter  = 1'b0;
         end
      endcase

      close_ok  = 1'b0;
      close_grp = ocp_pkg::GRP_A;
      if (ch == ocp_pkg::CH_DASH && cur_state.group_pos == ocp_pkg::GRP_A) begin
         close_ok  = 1'b1;
         close_grp = ocp_pkg::GRP_A;
      end else if (ch == ocp_pkg::CH_COLON && cur_state.group_pos <= ocp_pkg::GRP_B) begin
         close_ok  = 1'b1;
         close_grp = ocp_pkg::GRP_B;
      end else if (ch == ocp_pkg::CH_DOT && cur_state.group_pos <= ocp_pkg::GRP_D) begin
         close_ok  = 1'b1;
         close_grp = (cur_state.group_pos <= ocp_pkg::GRP_C) ? ocp_pkg::GRP_C
                                                              : ocp_pkg::GRP_D;
      end else if ((ch == ocp_pkg::CH_STAR || ch == ocp_pkg::CH_AMP) &&
                   cur_state.group_pos == ocp_pkg::GRP_E) begin
         close_ok  = 1'b1;
         close_grp = ocp_pkg::GRP_E;
      end
   end

   // acc * 10 + digit, as shifts and two adds
   assign prod = ({4'b0, cur_state.acc_low} << 3) + ({4'b0, cur_state.acc_low} << 1)
                 + {4'b0, digit};

   // State update and result
   always_comb begin
      s = cur_state;
      if (!cur_state.err_flag) begin
         if (s.chars_in_group != ocp_pkg::CHARS_MAX)
            s.chars_in_group = s.chars_in_group + 2'd1;
         if (is_digit) begin
            if (s.letter_seen) begin
               s.err_flag = 1'b1;
            end else begin
               if (prod > 12'd255)
                  s.acc_over = 1'b1;
               s.acc_low = prod[7:0];
            end
         end else if (is_letter) begin
            s.acc_low     = letter_val;
            s.acc_over    = 1'b0;
            s.letter_seen = 1'b1;
            if (s.chars_in_group > 2'd1)
               s.err_flag = 1'b1;
         end else if (!close_ok || s.acc_over) begin
            s.err_flag = 1'b1;
         end else begin
            for (int i = 0; i < ocp_pkg::GROUP_COUNT; i++) begin
               if (close_grp == 3'(i))
                  s.group_bytes[i] = s.acc_low;
            end
            s.group_pos      = close_grp + 3'd1;
            s.acc_low        = '0;
            s.acc_over       = 1'b0;
            s.chars_in_group = '0;
            s.letter_seen    = 1'b0;
         end
      end

      // Final character closes the open group; a string that ends before group D is an error
      if (last_char && !s.err_flag) begin
         for (int i = 0; i < ocp_pkg::GROUP_COUNT; i++) begin
            if (s.group_pos == 3'(i))
               s.group_bytes[i] = s.acc_low;
         end
         if (s.group_pos < ocp_pkg::GRP_D)
            s.err_flag = 1'b1;
      end

      b = s.err_flag ? {ocp_pkg::GROUP_COUNT{ocp_pkg::BYTE_NONE}} : s.group_bytes;

      result.medium_res   = b[ocp_pkg::GRP_A];
      result.channel_byte = b[ocp_pkg::GRP_B];
      result.indicator    = b[ocp_pkg::GRP_C];
      result.mode_byte    = b[ocp_pkg::GRP_D];
      result.quantity     = b[ocp_pkg::GRP_E];
      result.storage      = b[ocp_pkg::GRP_F];
      result.error        = s.err_flag;
      result.valid_id     = (b[ocp_pkg::GRP_A] <= 8'd9) && (b[ocp_pkg::GRP_B] <= 8'd64) &&
                            (b[ocp_pkg::GRP_F] == ocp_pkg::BYTE_NONE ||
                             b[ocp_pkg::GRP_F] <= 8'd99);
      result.vendor_specific =
         (b[ocp_pkg::GRP_B] >= 8'd128 && b[ocp_pkg::GRP_B] <= 8'd199) ||
         (b[ocp_pkg::GRP_C] >= 8'd128 && b[ocp_pkg::GRP_C] <= 8'd199) ||
         (b[ocp_pkg::GRP_C] == 8'd240) ||
         (b[ocp_pkg::GRP_D] >= 8'd128 && b[ocp_pkg::GRP_D] <= 8'd254) ||
         (b[ocp_pkg::GRP_E] >= 8'd128 && b[ocp_pkg::GRP_E] <= 8'd254) ||
         (b[ocp_pkg::GRP_F] >= 8'd128 && b[ocp_pkg::GRP_F] <= 8'd254);

      // A finished string leaves the parser in its reset state
      next_state = last_char ? ocp_pkg::reset_state() : s;
   end

endmodule

>>> rtl/core/obis_code_parser_unit.sv
// Top level of the identifier code parser: input register, character
// step logic and result register. Depends on ocp_pkg, ocp_if, ocp_char_step.
//
// Usage:
//   req_if carries one ASCII character per request (ch) and last_char,
//   which marks the final character of an A-B:C.D.E*F string.
//   rsp_if delivers one parsed code per string: the six group bytes
//   (255 where a group was not given, all 255 on error), the sticky
//   error flag, the basic validity flag and the manufacturer flag.
//   Throughput: one character per cycle while rsp_if takes its responses; the per-character
//   state update is one short combinational step between the input
//   register and the state/result registers.
//   Path: a request carrying last_char is held in the input register, then
//   its response is loaded into the result register, which drives rsp_if.valid.
//   Characters that are not last produce no response.
//   Reset (synchronous, active high) empties both register stages and
//   returns the parser to the start of a string.
//   A stalled rsp_if holds the response; the input register keeps taking
//   one request while the response waits, after which req_if.ready drops
//   until the response is taken.
module obis_code_parser_unit (
   input logic       clock,
   input logic       reset,
   ocp_req_if.sink   req_if,
   ocp_rsp_if.source rsp_if
);

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_ch_ff, s1_ch_in;
   logic               s1_last_ff, s1_last_in;
   ocp_pkg::state_type st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ocp_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   ocp_pkg::state_type step_state;
   ocp_pkg::rsp_type   step_result;
   logic               advance;
   logic               req_fire;

   ocp_char_step u_step (
      .cur_state  (st_ff),
      .ch         (s1_ch_ff),
      .last_char  (s1_last_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   // Handshake: the pipe moves whenever the result register can be loaded
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance || !s1_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;

   // Next values
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_ch_in     = s1_ch_ff;
      s1_last_in   = s1_last_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (advance) begin
         rsp_valid_in = s1_valid_ff && s1_last_ff;
         if (s1_valid_ff) begin
            st_in = step_state;
            if (s1_last_ff)
               rsp_data_in = step_result;
         end
         s1_valid_in = 1'b0;
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_ch_in    = req_if.ch;
         s1_last_in  = req_if.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= ocp_pkg::reset_state();
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
      s1_ch_ff    <= s1_ch_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Response port
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.medium_res      = rsp_data_ff.medium_res;
   assign rsp_if.channel_byte    = rsp_data_ff.channel_byte;
   assign rsp_if.indicator       = rsp_data_ff.indicator;
   assign rsp_if.mode_byte       = rsp_data_ff.mode_byte;
   assign rsp_if.quantity        = rsp_data_ff.quantity;
   assign rsp_if.storage         = rsp_data_ff.storage;
   assign rsp_if.error           = rsp_data_ff.error;
   assign rsp_if.valid_id        = rsp_data_ff.valid_id;
   assign rsp_if.vendor_specific = rsp_data_ff.vendor_specific;

   // A new response only ever follows a final character in the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response without a final character");

   // After the final character the parser is back at the start of a string
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_last_ff) |=>
         (st_ff.group_pos == ocp_pkg::GRP_A && !st_ff.err_flag &&
          st_ff.acc_low == 8'd0 && !st_ff.letter_seen))
      else $error("parser state not cleared after final character");

   // An error response carries empty C and D groups and no validity or vendor flag
   a_error_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error) |->
         (rsp_data_ff.indicator == ocp_pkg::BYTE_NONE &&
          rsp_data_ff.mode_byte == ocp_pkg::BYTE_NONE &&
          !rsp_data_ff.valid_id && !rsp_data_ff.vendor_specific))
      else $error("error response with group data");

   // Group position never runs past group F
   a_group_pos_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.group_pos <= ocp_pkg::GRP_F)
      else $error("group position out of range");

endmodule

>>> tb/obis_code_parser_unit_test.sv
// Testbench for obis_code_parser_unit: streams identifier strings one character
// per request and checks every parsed code against a predictor of the parser.
// Depends on ocp_pkg, ocp_if and the obis_code_parser_unit RTL.
`timescale 1ns / 1ps

module obis_code_parser_unit_test;
   import ocp_pkg::*;

   localparam int IDLE_PCT       = 9;
   localparam int STALL_LIMIT    = 1000;
   localparam int DRAIN_CYCLES   = 8;

   logic clock;
   logic reset;

   ocp_req_if req_ch ();
   ocp_rsp_if rsp_ch ();

   obis_code_parser_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predictor state of the parser
   logic [7:0] parse_bytes [GROUP_COUNT];
   logic [7:0] parse_acc;
   logic       parse_over;
   logic [2:0] parse_group;
   logic [1:0] parse_chars;
   logic       parse_letter;
   logic       parse_err;

   rsp_type expected_codes [$];
   int      chars_sent;
   int      mismatch_count;
   bit      no_stall;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic clear_parser();
      for (int i = 0; i < GROUP_COUNT; i++) parse_bytes[i] = BYTE_NONE;
      parse_acc    = '0;
      parse_over   = 1'b0;
      parse_group  = GRP_A;
      parse_chars  = '0;
      parse_letter = 1'b0;
      parse_err    = 1'b0;
   endtask

   // Update the predicted parser with one accepted request; queue a code on last_char
   task automatic advance_parser(input logic [7:0] c, input logic lst);
      int unsigned prod;
      int          closed;
      logic [7:0]  b [GROUP_COUNT];
      rsp_type     code;
      if (!parse_err) begin
         if (parse_chars < CHARS_MAX) parse_chars = parse_chars + 2'd1;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            if (parse_letter) begin
               parse_err = 1'b1;
            end else begin
               prod = parse_acc * 10 + (c - CH_ZERO);
               if (prod > 255) parse_over = 1'b1;
               parse_acc = prod[7:0];
            end
         end else if (c == CH_C || c == CH_F || c == CH_L || c == CH_P) begin
            case (c)
               CH_C:    parse_acc = VAL_C;
               CH_F:    parse_acc = VAL_F;
               CH_L:    parse_acc = VAL_L;
               default: parse_acc = VAL_P;
            endcase
            parse_over   = 1'b0;
            parse_letter = 1'b1;
            // letter only allowed as first character of a group
            if (parse_chars > 2'd1) parse_err = 1'b1;
         end else begin
            // separator: find the group it closes
            closed = -1;
            if (c == CH_DASH && parse_group == GRP_A) closed = GRP_A;
            else if (c == CH_COLON && parse_group <= GRP_B) closed = GRP_B;
            else if (c == CH_DOT && parse_group <= GRP_D)
               closed = (parse_group <= GRP_C) ? GRP_C : GRP_D;
            else if ((c == CH_STAR || c == CH_AMP) && parse_group == GRP_E) closed = GRP_E;
            if (closed < 0 || parse_over) begin
               parse_err = 1'b1;
            end else begin
               parse_bytes[closed] = parse_acc;
               parse_group  = 3'(closed + 1);
               parse_acc    = '0;
               parse_over   = 1'b0;
               parse_chars  = '0;
               parse_letter = 1'b0;
            end
         end
      end
      if (lst) begin
         // open group is closed without range check; C and D are mandatory
         if (!parse_err) begin
            parse_bytes[parse_group] = parse_acc;
            if (parse_group < GRP_D) parse_err = 1'b1;
         end
         for (int i = 0; i < GROUP_COUNT; i++) b[i] = parse_err ? BYTE_NONE : parse_bytes[i];
         code.medium_res      = b[GRP_A];
         code.channel_byte    = b[GRP_B];
         code.indicator       = b[GRP_C];
         code.mode_byte       = b[GRP_D];
         code.quantity        = b[GRP_E];
         code.storage         = b[GRP_F];
         code.error           = parse_err;
         code.valid_id        = b[GRP_A] <= 9 && b[GRP_B] <= 64 &&
                                (b[GRP_F] == BYTE_NONE || b[GRP_F] <= 99);
         code.vendor_specific = (b[GRP_B] >= 128 && b[GRP_B] <= 199) ||
                                (b[GRP_C] >= 128 && b[GRP_C] <= 199) || b[GRP_C] == 240 ||
                                (b[GRP_D] >= 128 && b[GRP_D] <= 254) ||
                                (b[GRP_E] >= 128 && b[GRP_E] <= 254) ||
                                (b[GRP_F] >= 128 && b[GRP_F] <= 254);
         expected_codes.push_back(code);
         clear_parser();
      end
   endtask

   // Send one character; valid stays high into the next call unless it idles
   task automatic send_char(input logic [7:0] c, input logic lst);
      while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.ch        <= c;
      req_ch.last_char <= lst;
      do @(posedge clock); while (!req_ch.ready);
      advance_parser(c, lst);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_bytes(ref logic [7:0] text[$]);
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   // Drop valid and wait until every queued code has come back
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_codes.size() != 0);
   endtask

   // One group: empty, a special letter or a decimal number
   task automatic add_group(ref logic [7:0] text[$]);
      int unsigned pick;
      int unsigned n;
      string       digits;
      pick = $urandom_range(99);
      if (pick < 5) begin
         return;
      end else if (pick < 17) begin
         case ($urandom_range(3))
            0:       text.push_back(CH_C);
            1:       text.push_back(CH_F);
            2:       text.push_back(CH_L);
            default: text.push_back(CH_P);
         endcase
      end else begin
         if (pick < 40) n = $urandom_range(9);
         else if (pick < 90) n = $urandom_range(255);
         else n = $urandom_range(999);
         if ($urandom_range(9) == 0) text.push_back(CH_ZERO);
         digits = $sformatf("%0d", n);
         for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
      end
   endtask

   // Well-formed A-B:C.D.E*F with the optional groups picked at random
   task automatic build_code(ref logic [7:0] text[$]);
      text.delete();
      if ($urandom_range(2) != 0) begin
         add_group(text);
         text.push_back(CH_DASH);
      end
      if ($urandom_range(2) != 0) begin
         add_group(text);
         text.push_back(CH_COLON);
      end
      add_group(text);
      text.push_back(CH_DOT);
      add_group(text);
      if ($urandom_range(2) != 0) begin
         text.push_back(CH_DOT);
         add_group(text);
         if ($urandom_range(1) == 1) begin
            text.push_back($urandom_range(1) == 1 ? CH_STAR : CH_AMP);
            add_group(text);
         end
      end
   endtask

   // Random strings: mostly well formed, some damaged, some pure noise
   task automatic test_random_codes(input int count);
      logic [7:0]  text [$];
      int unsigned pick;
      int          start;
      start = chars_sent;
      while (chars_sent - start < count) begin
         build_code(text);
         pick = $urandom_range(99);
         if (pick < 70) begin
            // keep as is
         end else if (pick < 80) begin
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
         end else if (pick < 88) begin
            text = text[0:$urandom_range(text.size() - 1)];
         end else if (pick < 94) begin
            case ($urandom_range(3))
               0:       text.insert($urandom_range(text.size()), CH_DASH);
               1:       text.insert($urandom_range(text.size()), CH_COLON);
               2:       text.insert($urandom_range(text.size()), CH_DOT);
               default: text.insert($urandom_range(text.size()), CH_STAR);
            endcase
         end else begin
            text.delete();
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
         end
         send_bytes(text);
      end
   endtask

   task automatic test_directed_codes();
      send_text("1-0:1.8.0*255");
      send_text("C.F");
      send_text("1-2:P.L.C&F");
      send_text("10-65:128.240.254*100");
      send_text("9-64:240.0.0*99");
      send_text("0-199:199.128.255*254");
      send_text("0000.C");
      send_text("1.2.");
      send_text("1.2.999");
      send_text("1C.2");
      send_text("C1.2");
      send_text("1.2-3");
      send_text("256.1");
      send_text("12");
      send_text("1-2:3");
      send_text(":");
      send_text("1.2x");
      send_text("1.2.3*4.5");
      send_text("7");
      // NUL and a byte above 127 are both errors
      send_char(8'h00, 1'b1);
      send_char(CH_ZERO, 1'b0);
      send_char(CH_DOT, 1'b0);
      send_char(CH_NINE, 1'b0);
      send_char(8'hb7, 1'b1);
   endtask

   // Several strings with the request side held off until results are back
   task automatic test_drain_pause();
      logic [7:0] text [$];
      repeat (4) begin
         build_code(text);
         send_bytes(text);
         hold_until_drained();
      end
   endtask

   // Both sides run without idling for a while
   task automatic test_full_rate(input int count);
      no_stall = 1'b1;
      test_random_codes(count);
      no_stall = 1'b0;
   endtask

   task automatic report_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Result side: check each accepted code and stall ready at random
   initial begin
      rsp_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_codes.size() == 0) begin
               $error("parsed code with no string pending");
               mismatch_count++;
            end else begin
               want = expected_codes.pop_front();
               report_field("medium_res", want.medium_res, rsp_ch.medium_res);
               report_field("channel_byte", want.channel_byte, rsp_ch.channel_byte);
               report_field("indicator", want.indicator, rsp_ch.indicator);
               report_field("mode_byte", want.mode_byte, rsp_ch.mode_byte);
               report_field("quantity", want.quantity, rsp_ch.quantity);
               report_field("storage", want.storage, rsp_ch.storage);
               report_field("error", want.error, rsp_ch.error);
               report_field("valid_id", want.valid_id, rsp_ch.valid_id);
               report_field("vendor_specific", want.vendor_specific, rsp_ch.vendor_specific);
            end
         end
         rsp_ch.ready <= no_stall || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // Watchdog: cycles in a row with no handshake on either side
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("obis_code_parser_unit_test: errors");
            $finish;
         end
      end
   end

   initial begin
      clear_parser();
      chars_sent       = 0;
      mismatch_count   = 0;
      no_stall         = 1'b0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.ch        <= '0;
      req_ch.last_char <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_codes();
      test_random_codes(220);
      test_drain_pause();
      test_full_rate(100);
      test_random_codes(220);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("obis_code_parser_unit_test: clean");
      end else begin
         $display("obis_code_parser_unit_test: errors");
      end
      $finish;
   end

endmodule
